FILE: hw/rtl/handle_table_allocator_defines.svh
// Assertion macros shared by the handle table RTL.
// Each expects clk and rst_n in scope.
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

// Check that cond implies prop in the same cycle.
`define HTA_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that cond implies prop in the next cycle.
`define HTA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/hta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hta_pkg;

    // Table geometry
    localparam int CAPACITY      = 1024;
    localparam int VALUE_WIDTH   = 32;
    localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);

    // Beat field widths
    localparam int OPCODE_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int HANDLE_W      = 11;
    localparam int VALUE_FIELD_W = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Per-handle bookkeeping: free mark and next link on the free list
    typedef struct packed {
        logic                mark;
        logic [HANDLE_W-1:0] link;
    } meta_t;

    localparam int META_W = $bits(meta_t);

endpackage

`default_nettype wire

FILE: hw/rtl/hta_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one operation per beat
interface hta_req_if;
    import hta_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic [HANDLE_W-1:0]      handle;
    logic [VALUE_FIELD_W-1:0] value_in;

    modport source (output valid, output opcode, output handle, output value_in,
                    input ready);
    modport sink   (input valid, input opcode, input handle, input value_in,
                    output ready);
endinterface

// Response channel: one result per beat
interface hta_rsp_if;
    import hta_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [HANDLE_W-1:0]      handle_out;
    logic [VALUE_FIELD_W-1:0] value_out;
    logic [HANDLE_W-1:0]      in_use_count;
    logic                     is_empty;

    modport source (output valid, output status, output handle_out, output value_out,
                    output in_use_count, output is_empty, input ready);
    modport sink   (input valid, input status, input handle_out, input value_out,
                    input in_use_count, input is_empty, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/hta_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hta_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/handle_table_allocator.sv
// An accepted request beat is captured with its table read, then executes in S_EXEC once the output register is free.
// Each request is a table read, then read-modify-write of the entry; the next is taken after it executes.
// A new request is taken while the previous response still waits in the output register.
// Reset clears the state machine, free-list head, issued/freed counters and response valid.
// The value and bookkeeping memories are not cleared; entries are written before their read data is used.
`timescale 1ns / 1ps
`default_nettype none
`include "handle_table_allocator_defines.svh"

module handle_table_allocator (
    input wire logic clk,
    input wire logic rst_n,
    hta_req_if.sink  req,
    hta_rsp_if.source rsp
);
    import hta_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Control state
    logic [HANDLE_W-1:0] free_head_reg, free_head_next;
    logic [COUNT_W-1:0]  issued_count_reg, issued_count_next;
    logic [COUNT_W-1:0]  freed_count_reg, freed_count_next;
    logic                rsp_valid_reg;

    // Captured request
    logic [OPCODE_W-1:0]    op_reg;
    logic [HANDLE_W-1:0]    h_reg;
    logic [VALUE_WIDTH-1:0] v_reg;

    // Response payload
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [HANDLE_W-1:0]      hout_reg, hout_next;
    logic [VALUE_FIELD_W-1:0] vout_reg, vout_next;
    logic [HANDLE_W-1:0]      in_use_reg, in_use_next;
    logic                     empty_reg, empty_next;

    // Memory ports
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   val_we;
    logic                   meta_we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] val_rdata;
    logic [META_W-1:0]      meta_rdata_bits;
    meta_t                  meta_rdata;
    meta_t                  meta_wdata;

    logic accept;
    logic fire;
    logic live;
    logic [HANDLE_W-1:0] alloc_h;

    hta_ram #(.DEPTH(CAPACITY), .WIDTH(VALUE_WIDTH)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (v_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    hta_ram #(.DEPTH(CAPACITY), .WIDTH(META_W)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (wr_addr),
        .wdata (meta_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (meta_rdata_bits)
    );

    assign meta_rdata = meta_t'(meta_rdata_bits);

    // Handshake
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    // Issue the table read on accept: free-list top for allocate, else the given handle
    always_comb
    begin
        rd_en = accept;
        if (req.opcode == OP_ALLOC)
        begin
            rd_addr = ADDR_W'(free_head_reg - HANDLE_W'(1));
        end
        else
        begin
            rd_addr = ADDR_W'(req.handle - HANDLE_W'(1));
        end
    end

    // Handle is issued and not on the free list
    assign live = (h_reg != '0) && (32'(h_reg) <= 32'(issued_count_reg)) && !meta_rdata.mark;

    // Execute the captured operation against the read data
    always_comb
    begin
        free_head_next    = free_head_reg;
        issued_count_next = issued_count_reg;
        freed_count_next  = freed_count_reg;
        status_next       = ST_INVALID;
        hout_next         = '0;
        vout_next         = '0;
        val_we            = 1'b0;
        meta_we           = 1'b0;
        wr_addr           = ADDR_W'(h_reg - HANDLE_W'(1));
        meta_wdata.mark   = 1'b1;
        meta_wdata.link   = free_head_reg;
        alloc_h           = '0;

        unique case (op_reg)
            OP_ALLOC:
            begin
                if (free_head_reg != '0)
                begin
                    alloc_h          = free_head_reg;
                    free_head_next   = meta_rdata.link;
                    freed_count_next = freed_count_reg - COUNT_W'(1);
                end
                else if (32'(issued_count_reg) < CAPACITY)
                begin
                    issued_count_next = issued_count_reg + COUNT_W'(1);
                    alloc_h           = HANDLE_W'(issued_count_next);
                end

                if (alloc_h != '0)
                begin
                    val_we          = fire;
                    meta_we         = fire;
                    wr_addr         = ADDR_W'(alloc_h - HANDLE_W'(1));
                    meta_wdata.mark = 1'b0;
                    meta_wdata.link = '0;
                    status_next     = ST_OK;
                    hout_next       = alloc_h;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_FREE:
            begin
                if (live)
                begin
                    meta_we          = fire;
                    free_head_next   = h_reg;
                    freed_count_next = freed_count_reg + COUNT_W'(1);
                    status_next      = ST_OK;
                    hout_next        = h_reg;
                    vout_next        = VALUE_FIELD_W'(val_rdata);
                end
            end
            OP_LOOKUP:
            begin
                if (live)
                begin
                    status_next = ST_OK;
                    hout_next   = h_reg;
                    vout_next   = VALUE_FIELD_W'(val_rdata);
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase

        in_use_next = HANDLE_W'(issued_count_next - freed_count_next);
        empty_next  = (issued_count_next == freed_count_next);
    end

    // Advance the state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            free_head_reg    <= '0;
            issued_count_reg <= '0;
            freed_count_reg  <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                free_head_reg    <= free_head_next;
                issued_count_reg <= issued_count_next;
                freed_count_reg  <= freed_count_next;
                rsp_valid_reg    <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request beat and load the response beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req.opcode;
            h_reg  <= req.handle;
            v_reg  <= req.value_in[VALUE_WIDTH-1:0];
        end
        if (fire)
        begin
            status_reg <= status_next;
            hout_reg   <= hout_next;
            vout_reg   <= vout_next;
            in_use_reg <= in_use_next;
            empty_reg  <= empty_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.handle_out   = hout_reg;
    assign rsp.value_out    = vout_reg;
    assign rsp.in_use_count = in_use_reg;
    assign rsp.is_empty     = empty_reg;

    // Checks
    `HTA_ASSERT_NOW(a_counts_ordered, 1'b1, freed_count_reg <= issued_count_reg,
        "freed count exceeds issued count")
    `HTA_ASSERT_NOW(a_head_needs_freed, free_head_reg != '0, freed_count_reg != '0,
        "free list head set with no freed handles")
    `HTA_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC,
        "accepted request did not enter execute")
    `HTA_ASSERT_NOW(a_empty_consistent, rsp_valid_reg && empty_reg, in_use_reg == '0,
        "empty flag set with nonzero in-use count")

endmodule

`default_nettype wire

FILE: tb/sv/tb_handle_table_allocator.sv
`timescale 1ns / 1ps

module tb_handle_table_allocator;
    import hta_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 1550;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_HANDLE   = (1 << HANDLE_W) - 1;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [HANDLE_W-1:0]      handle;
        logic [VALUE_FIELD_W-1:0] value;
    } table_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [HANDLE_W-1:0]      handle;
        logic [VALUE_FIELD_W-1:0] value;
        logic [HANDLE_W-1:0]      in_use;
        logic                     empty;
    } table_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    hta_req_if req ();
    hta_rsp_if rsp ();

    handle_table_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Operations waiting to be offered, and answers waiting to come back
    table_op_t     op_queue[$];
    table_answer_t awaited_answers[$];

    // Shadow of the handle table
    logic [VALUE_FIELD_W-1:0] tbl_value [1:CAPACITY];
    bit                       tbl_freed [1:CAPACITY];
    int unsigned              tbl_next  [1:CAPACITY];
    int unsigned              free_top;
    int unsigned              n_issued;
    int unsigned              n_freed;

    // Bookkeeping that aims the stimulus at live and freed handles and counts the queued operations
    int gen_live_pool[$];
    int gen_free_stack[$];
    int gen_issued;
    int gen_total;

    int  n_accepted;
    int  n_bad;
    int  cycle_count;
    bit  req_fire;
    bit  rsp_fire;
    bit  offering;
    bit  tx_burst;
    bit  rx_burst;
    int  tx_wait;
    int  rx_wait;
    int  hold_left;
    bit  hold_done;
    logic rx_hold;
    table_op_t next_op;

    function automatic bit handle_is_live(int unsigned h);
        if (h == 0 || h > n_issued || h > CAPACITY)
            return 1'b0;
        return !tbl_freed[h];
    endfunction

    // Apply one operation to the shadow table and return the answer it earns
    function automatic table_answer_t apply_table_op(table_op_t op);
        table_answer_t a;
        int unsigned   n;
        int unsigned   h;
        a        = '0;
        a.status = ST_INVALID;
        h        = op.handle;
        n        = 0;
        if (op.opcode == OP_ALLOC) begin
            if (free_top != 0) begin
                n        = free_top;
                free_top = tbl_next[n];
                n_freed--;
            end
            else if (n_issued < CAPACITY) begin
                n_issued++;
                n = n_issued;
            end
            if (n != 0) begin
                tbl_value[n] = op.value;
                tbl_freed[n] = 1'b0;
                a.status     = ST_OK;
                a.handle     = n[HANDLE_W-1:0];
            end
            else begin
                a.status = ST_FULL;
            end
        end
        else if (op.opcode == OP_FREE) begin
            if (handle_is_live(h)) begin
                a.value      = tbl_value[h];
                tbl_freed[h] = 1'b1;
                tbl_next[h]  = free_top;
                free_top     = h;
                n_freed++;
                a.status     = ST_OK;
                a.handle     = op.handle;
            end
        end
        else if (op.opcode == OP_LOOKUP) begin
            if (handle_is_live(h)) begin
                a.value  = tbl_value[h];
                a.status = ST_OK;
                a.handle = op.handle;
            end
        end
        a.in_use = HANDLE_W'(n_issued - n_freed);
        a.empty  = (n_issued == n_freed);
        return a;
    endfunction

    // Queue one operation and track which handles it leaves live or freed
    task automatic queue_op(logic [OPCODE_W-1:0] opc, int h, logic [VALUE_FIELD_W-1:0] v);
        table_op_t op;
        int        n;
        int        idx;
        op.opcode = opc;
        op.handle = h[HANDLE_W-1:0];
        op.value  = v;
        op_queue.push_back(op);
        gen_total++;
        if (opc == OP_ALLOC) begin
            n = 0;
            if (gen_free_stack.size() != 0)
                n = gen_free_stack.pop_back();
            else if (gen_issued < CAPACITY) begin
                gen_issued++;
                n = gen_issued;
            end
            if (n != 0)
                gen_live_pool.push_back(n);
        end
        else if (opc == OP_FREE) begin
            idx = -1;
            foreach (gen_live_pool[i])
                if (gen_live_pool[i] == h)
                    idx = i;
            if (idx >= 0) begin
                gen_live_pool.delete(idx);
                gen_free_stack.push_back(h);
            end
        end
    endtask

    // Mostly live handles, with freed, zero, unissued and out-of-range ones mixed in
    function automatic int choose_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && gen_live_pool.size() != 0)
            return gen_live_pool[$urandom_range(0, gen_live_pool.size() - 1)];
        if (r < 80 && gen_free_stack.size() != 0)
            return gen_free_stack[$urandom_range(0, gen_free_stack.size() - 1)];
        if (r < 85)
            return 0;
        if (r < 90 && gen_issued < CAPACITY)
            return $urandom_range(gen_issued + 1, CAPACITY);
        return $urandom_range(0, MAX_HANDLE);
    endfunction

    task automatic queue_random_op(int p_alloc, int p_lookup, int p_free);
        int r;
        r = $urandom_range(0, 99);
        if (r < p_alloc)
            queue_op(OP_ALLOC, $urandom_range(0, MAX_HANDLE), $urandom);
        else if (r < p_alloc + p_lookup)
            queue_op(OP_LOOKUP, choose_target(), $urandom);
        else if (r < p_alloc + p_lookup + p_free)
            queue_op(OP_FREE, choose_target(), $urandom);
        else
            queue_op(OP_UNUSED, $urandom_range(0, MAX_HANDLE), $urandom);
    endtask

    task automatic flag_bad_beat(string msg);
        n_bad++;
        if (n_bad <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Build the stimulus, run reset, then wait for the last answer
    initial begin
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.opcode   = '0;
        req.handle   = '0;
        req.value_in = '0;
        rsp.ready    = 1'b0;
        rx_hold      = 1'b0;

        // Empty table: zero and unissued handles, unused opcode
        queue_op(OP_LOOKUP, 0, 32'h0);
        queue_op(OP_FREE, 0, 32'h0);
        queue_op(OP_LOOKUP, 1, 32'h0);
        queue_op(OP_UNUSED, 1, 32'hFFFF_FFFF);
        // First handles, value extremes
        queue_op(OP_ALLOC, MAX_HANDLE, 32'h0000_0000);
        queue_op(OP_ALLOC, 0, 32'hFFFF_FFFF);
        queue_op(OP_ALLOC, 5, 32'hA5A5_5A5A);
        queue_op(OP_LOOKUP, 1, 32'h0);
        queue_op(OP_LOOKUP, 2, 32'hFFFF_FFFF);
        queue_op(OP_LOOKUP, MAX_HANDLE, 32'h0);
        queue_op(OP_LOOKUP, CAPACITY, 32'h0);
        // Free, double free, lookup of a freed handle
        queue_op(OP_FREE, 2, 32'h0);
        queue_op(OP_FREE, 2, 32'h0);
        queue_op(OP_LOOKUP, 2, 32'h0);
        queue_op(OP_FREE, 1, 32'h0);
        // Reuse in last-freed-first order, then a fresh handle
        queue_op(OP_ALLOC, 0, 32'h1234_5678);
        queue_op(OP_ALLOC, 0, 32'h8765_4321);
        queue_op(OP_ALLOC, 0, 32'h0F0F_F0F0);
        // Drain to empty
        queue_op(OP_FREE, 3, 32'h0);
        queue_op(OP_FREE, 1, 32'h0);
        queue_op(OP_FREE, 2, 32'h0);
        queue_op(OP_FREE, 4, 32'h0);
        queue_op(OP_UNUSED, MAX_HANDLE, 32'hFFFF_FFFF);

        // Fill the table, mostly allocating
        while (gen_issued < CAPACITY)
            queue_random_op(90, 5, 3);
        while (gen_free_stack.size() != 0)
            queue_op(OP_ALLOC, 0, $urandom);
        // Full table and the top handle
        queue_op(OP_ALLOC, 0, $urandom);
        queue_op(OP_LOOKUP, CAPACITY, 32'h0);
        queue_op(OP_FREE, CAPACITY, 32'h0);
        queue_op(OP_ALLOC, 0, $urandom);
        queue_op(OP_ALLOC, 0, $urandom);
        queue_op(OP_LOOKUP, CAPACITY, 32'h0);

        // Churn near capacity: alternate free-heavy and allocate-heavy stretches
        while (gen_total < ITEM_TARGET) begin
            if ((gen_total / 60) % 2 == 0)
                queue_random_op(20, 25, 45);
            else
                queue_random_op(50, 20, 20);
        end

        repeat (5) @(posedge clk);
        #2 rst_n = 1'b1;

        while (n_accepted < gen_total)
            @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_bad == 0 && awaited_answers.size() == 0)
            $display("PASS handle_table_allocator");
        else
            $display("FAIL handle_table_allocator");
        $finish;
    end

    // Predict the answer for every accepted request beat
    always @(posedge clk) begin
        req_fire = rst_n && req.valid && req.ready;
        if (req_fire) begin
            awaited_answers.push_back(apply_table_op('{req.opcode, req.handle, req.value_in}));
            n_accepted++;
        end
    end

    // Request driver: hold each beat until taken, then idle a drawn number of cycles
    always @(negedge clk) begin
        if (rst_n) begin
            if (req_fire) begin
                offering = 1'b0;
                if ($urandom_range(0, 47) == 0)
                    tx_burst = !tx_burst;
                tx_wait = tx_burst ? 0 : $urandom_range(0, 8);
            end
            else if (!offering && tx_wait > 0) begin
                tx_wait--;
            end
            if (!offering && tx_wait == 0 && op_queue.size() != 0) begin
                next_op       = op_queue.pop_front();
                req.opcode   <= next_op.opcode;
                req.handle   <= next_op.handle;
                req.value_in <= next_op.value;
                offering      = 1'b1;
            end
            req.valid <= offering;
        end
    end

    // Hold off the receiver once for a long stretch to back up the block
    always @(negedge clk) begin
        if (hold_left > 0)
            hold_left--;
        else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        rx_hold <= (hold_left != 0);
    end

    // Response ready: stall a drawn number of cycles after each beat
    always @(negedge clk) begin
        if (rst_n) begin
            if (rsp_fire) begin
                if ($urandom_range(0, 47) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 8);
            end
            else if (rx_wait > 0) begin
                rx_wait--;
            end
            rsp.ready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // Check each response beat against the oldest predicted answer
    always @(posedge clk) begin
        table_answer_t got;
        table_answer_t want;
        rsp_fire = rst_n && rsp.valid && rsp.ready;
        if (rsp_fire) begin
            got = '{rsp.status, rsp.handle_out, rsp.value_out, rsp.in_use_count, rsp.is_empty};
            if (awaited_answers.size() == 0) begin
                flag_bad_beat($sformatf("unexpected response: status %0d handle %0d value %h",
                                        got.status, got.handle, got.value));
            end
            else begin
                want = awaited_answers.pop_front();
                if (got !== want)
                    flag_bad_beat($sformatf({"mismatch: expected status %0d handle %0d ",
                        "value %h count %0d empty %0b, got status %0d handle %0d ",
                        "value %h count %0d empty %0b"},
                        want.status, want.handle, want.value, want.in_use, want.empty,
                        got.status, got.handle, got.value, got.in_use, got.empty));
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL handle_table_allocator");
            $finish;
        end
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hta_pkg.sv
hw/rtl/hta_if.sv
hw/rtl/hta_ram.sv
hw/rtl/handle_table_allocator.sv
tb/sv/tb_handle_table_allocator.sv
